// File: design/pef_pkg.sv
// ----------------------------------------------------------------------------
// pef_pkg
// Shared types and constants for the postfix expression evaluator: stack
// sizing, operation and status codes, item structs and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pef_pkg;

   // stack sizing
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // data path sizing
   localparam int WORD_W      = 32;
   localparam int STEP_W      = $clog2(WORD_W);
   localparam int OP_W        = 3;

   // operation codes, six and seven are unused
   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_FINISH = 3'd5
   } pef_op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_UNDER   = 2'd1,
      STAT_OVER    = 2'd2,
      STAT_DIVZERO = 2'd3
   } pef_status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_ABS_L,
      ST_ABS_R,
      ST_DIV,
      ST_NEG
   } pef_state_type;

   // input item
   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] operand_value;
   } pef_req_type;

   // result item
   typedef struct packed {
      logic signed [WORD_W-1:0] top_value;
      pef_status_type           status;
      logic                     done_res;
   } pef_rsp_type;

endpackage

// File: design/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit: 32-bit stack machine for postfix input
// push, finish, faulting and unused items: result registered in the cycle after acceptance
// add/subtract, multiply and divide all use one shared 32-bit adder, stepping a
// shift-add or restoring-divide loop for multiply and divide
// next item is taken once the sequencer is idle and no result is held by rsp_stall; reset empties the stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pef_pkg::pef_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pef_pkg::pef_rsp_type rsp_data
);
   import pef_pkg::*;

   // stack storage below the top entry
   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

   // control state
   pef_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // data registers
   pef_rsp_type       rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0] top_ff, top_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] opa_ff, opa_in;
   logic [WORD_W-1:0] opb_ff, opb_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [OP_W-1:0]   op_ff, op_in;

   // memory port
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [PTR_W-1:0]  mem_raddr;
   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  count_m2;

   // shared adder
   logic [WORD_W-1:0] add_a, add_b, add_sum;
   logic              add_cin, add_cout;

   // misc
   logic              req_fire;
   logic [WORD_W-1:0] cur_top;
   logic [WORD_W-1:0] rem_shift;
   logic              fin_en;
   logic [WORD_W-1:0] fin_val;

   // handshake
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stack pointers
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);
   assign mem_waddr = count_m1[PTR_W-1:0];
   assign mem_raddr = count_m2[PTR_W-1:0];
   assign cur_top   = (count_ff == '0) ? '0 : top_ff;

   // the one adder, with carry out for the divide compare
   assign {add_cout, add_sum} = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};

   // remainder shifted by one with the next dividend bit
   assign rem_shift = {acc_ff[WORD_W-2:0], opa_ff[WORD_W-1]};

   // sequencer: next state and data path control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      top_in       = top_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      op_in        = op_ff;
      mem_we       = 1'b0;
      add_a        = '0;
      add_b        = '0;
      add_cin      = 1'b0;
      fin_en       = 1'b0;
      fin_val      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.top_value = cur_top;
               rsp_data_in.status    = STAT_OK;
               rsp_data_in.done_res  = 1'b0;
               unique case (req_data.operation) inside
                  OP_PUSH: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_data_in.status = STAT_OVER;
                     end else begin
                        // old top drops into the memory
                        mem_we                = (count_ff != '0);
                        top_in                = req_data.operand_value;
                        count_in              = count_ff + CNT_W'(1);
                        rsp_data_in.top_value = req_data.operand_value;
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_data_in.status = STAT_UNDER;
                     end else if (req_data.operation == OP_DIV && top_ff == '0) begin
                        rsp_data_in.status = STAT_DIVZERO;
                     end else begin
                        // second entry is read this cycle
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        rsp_data_in  = rsp_data_ff;
                        op_in        = req_data.operation;
                        state_in     = ST_FETCH;
                     end
                  end
                  OP_FINISH: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = STAT_UNDER;
                     end else begin
                        rsp_data_in.done_res = 1'b1;
                        count_in             = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FETCH: begin
            unique case (op_ff) inside
               OP_ADD: begin
                  add_a   = rd_data_ff;
                  add_b   = top_ff;
                  fin_en  = 1'b1;
                  fin_val = add_sum;
               end
               OP_SUB: begin
                  add_a   = rd_data_ff;
                  add_b   = ~top_ff;
                  add_cin = 1'b1;
                  fin_en  = 1'b1;
                  fin_val = add_sum;
               end
               OP_MUL: begin
                  acc_in   = '0;
                  opa_in   = rd_data_ff;
                  opb_in   = top_ff;
                  step_in  = '0;
                  state_in = ST_MUL;
               end
               OP_DIV: begin
                  opa_in   = rd_data_ff;
                  opb_in   = top_ff;
                  neg_in   = rd_data_ff[WORD_W-1] ^ top_ff[WORD_W-1];
                  state_in = ST_ABS_L;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // shift-add, one multiplier bit a cycle
         ST_MUL: begin
            add_a   = acc_ff;
            add_b   = opb_ff[0] ? opa_ff : '0;
            acc_in  = add_sum;
            opa_in  = {opa_ff[WORD_W-2:0], 1'b0};
            opb_in  = {1'b0, opb_ff[WORD_W-1:1]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(WORD_W - 1)) begin
               fin_en  = 1'b1;
               fin_val = add_sum;
            end
         end

         // magnitude of the dividend
         ST_ABS_L: begin
            add_a   = ~opa_ff;
            add_cin = 1'b1;
            if (opa_ff[WORD_W-1]) begin
               opa_in = add_sum;
            end
            state_in = ST_ABS_R;
         end

         // magnitude of the divisor
         ST_ABS_R: begin
            add_a   = ~opb_ff;
            add_cin = 1'b1;
            if (opb_ff[WORD_W-1]) begin
               opb_in = add_sum;
            end
            acc_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end

         // restoring divide, one quotient bit a cycle
         ST_DIV: begin
            add_a   = rem_shift;
            add_b   = ~opb_ff;
            add_cin = 1'b1;
            acc_in  = add_cout ? add_sum : rem_shift;
            opa_in  = {opa_ff[WORD_W-2:0], add_cout};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(WORD_W - 1)) begin
               state_in = ST_NEG;
            end
         end

         // quotient sign
         ST_NEG: begin
            add_a   = ~opa_ff;
            add_cin = 1'b1;
            fin_en  = 1'b1;
            fin_val = neg_ff ? add_sum : opa_ff;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // binary operation completes: result replaces the two entries
      if (fin_en) begin
         top_in                = fin_val;
         count_in              = count_m1;
         rsp_valid_in          = 1'b1;
         rsp_data_in.top_value = fin_val;
         rsp_data_in.status    = STAT_OK;
         rsp_data_in.done_res  = 1'b0;
         state_in              = ST_IDLE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      top_ff      <= top_in;
      acc_ff      <= acc_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      op_ff       <= op_in;
   end

   // stack memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= top_ff;
      end
      rd_data_ff <= stack_mem[mem_raddr];
   end

`ifndef ASSERT_OFF
   // stack never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // no item taken while the sequencer is busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input not stalled while busy");

   // a finish leaves the stack empty
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.operation == OP_FINISH) |=> (count_ff == '0))
      else $error("stack not emptied by finish");

   // a divide ends with a result and an idle sequencer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEG) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("divide did not deliver its result");

   // a finished expression always reports ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> (rsp_data_ff.status == STAT_OK))
      else $error("finished expression with fault status");
`endif

endmodule
